@@ design/fws_pkg.sv @@
package fws_pkg;

	localparam int MAX_TERMS       = 64;
	localparam int PHASE_BITS      = 24;
	localparam int SINE_TABLE_BITS = 10;

	localparam int J_W  = $clog2(MAX_TERMS);
	localparam int KMAX = 2 * MAX_TERMS - 3;
	localparam int D_W  = $clog2(KMAX * KMAX + 1);

	localparam int CORDIC_ITERS = 24;
	localparam int CX_W         = 34;
	localparam int CZ_W         = 33;

	localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);
	localparam logic [31:0]            ENV_ONE     = 32'h4000_0000;

	localparam int SUM_W = 40;
	localparam int AB_W  = SUM_W + 17;
	localparam int T_W   = 42;
	localparam int SMP_W = T_W + 16 - 22;

	localparam logic signed [CZ_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
		CZ_W'(536870912), CZ_W'(316933406), CZ_W'(167458907), CZ_W'(85004756),
		CZ_W'(42667331),  CZ_W'(21354465),  CZ_W'(10679838),  CZ_W'(5340245),
		CZ_W'(2670163),   CZ_W'(1335087),   CZ_W'(667544),    CZ_W'(333772),
		CZ_W'(166886),    CZ_W'(83443),     CZ_W'(41722),     CZ_W'(20861),
		CZ_W'(10430),     CZ_W'(5215),      CZ_W'(2608),      CZ_W'(1304),
		CZ_W'(652),       CZ_W'(326),       CZ_W'(163),       CZ_W'(81)
	};

	typedef enum logic [1:0] {
		WAVE_SQUARE   = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_SINE     = 2'd3
	} wave_t;

	typedef enum logic [2:0] {
		REG_WAVE  = 3'd0,
		REG_TERMS = 3'd1,
		REG_STEP  = 3'd2,
		REG_AMP   = 3'd3,
		REG_DECAY = 3'd4
	} reg_idx_t;

	typedef struct packed {
		wave_t                   wave;
		logic [6:0]              term_limit;
		logic [PHASE_BITS-1:0]   phase_step;
		logic signed [15:0]      amplitude;
		logic [31:0]             decay;
	} fws_cfg_t;

	typedef struct packed {
		logic           start;
		logic           restart;
		logic           issue;
		logic [J_W-1:0] j;
		logic           post1;
		logic           post2;
		logic           post3;
		logic           finish;
	} fws_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} fws_stat_t;

	typedef struct packed {
		logic           neg;
		logic [J_W-1:0] j;
	} fws_tag_t;

endpackage

@@ design/fws_cordic.sv @@
module fws_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [fws_pkg::CZ_W-1:0] in_z,
	input  fws_pkg::fws_tag_t             in_tag,
	output logic                          out_valid,
	output logic signed [fws_pkg::CX_W-1:0] out_y,
	output fws_pkg::fws_tag_t             out_tag,
	output logic                          busy
);
	import fws_pkg::*;

	logic signed [CX_W-1:0] x_s [0:CORDIC_ITERS];
	logic signed [CX_W-1:0] y_s [0:CORDIC_ITERS];
	logic signed [CZ_W-1:0] z_s [0:CORDIC_ITERS];
	fws_tag_t               tag_s [0:CORDIC_ITERS];
	logic [CORDIC_ITERS:0]  v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[CORDIC_ITERS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= CORDIC_GAIN;
		y_s[0]   <= '0;
		z_s[0]   <= in_z;
		tag_s[0] <= in_tag;
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (z_s[i][CZ_W-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_TURNS[i];
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_TURNS[i];
			end
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = v_s[CORDIC_ITERS];
	assign out_y     = y_s[CORDIC_ITERS];
	assign out_tag   = tag_s[CORDIC_ITERS];
	assign busy      = |v_s;

endmodule

@@ design/fws_datapath.sv @@
module fws_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  fws_pkg::fws_cfg_t   cfg,
	input  fws_pkg::fws_cmd_t   cmd,
	output fws_pkg::fws_stat_t  stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [0:0]          m_tuser
);
	import fws_pkg::*;

	localparam logic signed [SMP_W-1:0] SMP_MAX = SMP_W'(64'sh7FFF_FFFF);
	localparam logic signed [SMP_W-1:0] SMP_MIN = ~SMP_MAX;

	logic [31:0]    recip_odd [MAX_TERMS];
	logic [31:0]    recip_tri [MAX_TERMS];
	logic [31:0]    recip_saw [MAX_TERMS];
	logic [D_W-1:0] div_odd   [MAX_TERMS];
	logic [D_W-1:0] div_tri   [MAX_TERMS];
	logic [D_W-1:0] div_saw   [MAX_TERMS];

	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tab
		localparam int unsigned KO = (g == 0) ? 1 : 2 * g - 1;
		localparam int unsigned KS = (g == 0) ? 1 : g;
		localparam logic [31:0] R_ODD = 32'hFFFF_FFFF / KO;
		localparam logic [31:0] R_TRI = 32'hFFFF_FFFF / (KO * KO);
		localparam logic [31:0] R_SAW = 32'hFFFF_FFFF / KS;
		assign recip_odd[g] = R_ODD;
		assign recip_tri[g] = R_TRI;
		assign recip_saw[g] = R_SAW;
		assign div_odd[g]   = D_W'(KO);
		assign div_tri[g]   = D_W'(KO * KO);
		assign div_saw[g]   = D_W'(KS);
	end

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] harm_q;
	logic [PHASE_BITS-1:0] base;
	logic [31:0]           env_q;

	assign base = cmd.restart ? '0 : phase_acc_q;

	// Harmonic phase is built by repeated addition, one harmonic per cycle.
	logic [31:0]         ang;
	logic                fold;
	logic [31:0]         ang_f;
	fws_tag_t            tag_in;
	logic signed [CZ_W-1:0] z_in;

	always_comb begin
		ang    = {harm_q[PHASE_BITS-1 -: SINE_TABLE_BITS], (32 - SINE_TABLE_BITS)'(0)};
		fold   = ang[31] ^ ang[30];
		ang_f  = {ang[31] ^ fold, ang[30:0]};
		z_in   = {ang_f[31], ang_f};
		tag_in.j   = cmd.j;
		tag_in.neg = fold ^ (((cfg.wave == WAVE_TRIANGLE) || (cfg.wave == WAVE_SAW))
			&& cmd.j[0]);
	end

	logic                   c_valid;
	logic signed [CX_W-1:0] c_y;
	fws_tag_t               c_tag;
	logic                   c_busy;

	fws_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.issue),
		.in_z      (z_in),
		.in_tag    (tag_in),
		.out_valid (c_valid),
		.out_y     (c_y),
		.out_tag   (c_tag),
		.busy      (c_busy)
	);

	logic signed [CX_W-1:0] s_val;
	logic [31:0]            r_sel;
	logic [D_W-1:0]         d_sel;

	always_comb begin
		s_val = c_tag.neg ? -c_y : c_y;
		unique case (cfg.wave)
			WAVE_SQUARE: begin
				r_sel = recip_odd[c_tag.j];
				d_sel = div_odd[c_tag.j];
			end
			WAVE_TRIANGLE: begin
				r_sel = recip_tri[c_tag.j];
				d_sel = div_tri[c_tag.j];
			end
			WAVE_SAW: begin
				r_sel = recip_saw[c_tag.j];
				d_sel = div_saw[c_tag.j];
			end
			default: begin
				r_sel = 32'hFFFF_FFFF;
				d_sel = D_W'(1);
			end
		endcase
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0]          mag_s1, mag_s2, mag_s3;
	logic                 sgn_s1, sgn_s2, sgn_s3;
	logic [31:0]          r_s1;
	logic [D_W-1:0]       d_s1, d_s2, d_s3;
	logic [31:0]          q0_s2, q0_s3;
	logic [31+D_W:0]      qd_s3;
	logic signed [32:0]   term_s4;
	logic signed [SUM_W-1:0] sum_q;

	logic [CX_W-1:0]  s_abs;
	logic [63:0]      mr;
	logic [31+D_W:0]  rem;
	logic [31:0]      q;

	always_comb begin
		s_abs = s_val[CX_W-1] ? CX_W'(-s_val) : CX_W'(s_val);
		mr    = 64'(mag_s1) * 64'(r_s1);
		rem   = (32 + D_W)'(mag_s3) - qd_s3;
		q     = q0_s3 + 32'(rem >= (32 + D_W)'(d_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= c_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Quotient by reciprocal: the estimate is exact or one short, then one correction.
	always_ff @(posedge clk) begin
		mag_s1  <= s_abs[31:0];
		sgn_s1  <= s_val[CX_W-1];
		r_s1    <= r_sel;
		d_s1    <= d_sel;
		q0_s2   <= mr[63:32];
		mag_s2  <= mag_s1;
		sgn_s2  <= sgn_s1;
		d_s2    <= d_s1;
		qd_s3   <= (32 + D_W)'(q0_s2) * (32 + D_W)'(d_s2);
		q0_s3   <= q0_s2;
		mag_s3  <= mag_s2;
		sgn_s3  <= sgn_s2;
		d_s3    <= d_s2;
		term_s4 <= sgn_s3 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end

	logic signed [AB_W-1:0]   a_s2, b_s2;
	logic signed [AB_W-1:0]   ab_sum;
	logic signed [T_W-1:0]    t_s3;
	logic signed [T_W+15:0]   tp;
	logic signed [SMP_W-1:0]  smp_s4;
	logic [63:0]              envp_s2;
	logic [31:0]              env_new_s3;
	logic                     env_sat_s3;

	assign ab_sum = a_s2 + (b_s2 >>> 16);
	assign tp     = t_s3 * cfg.amplitude;

	always_ff @(posedge clk) begin
		if (cmd.post1) begin
			a_s2    <= sum_q * $signed({1'b0, env_q[31:16]});
			b_s2    <= sum_q * $signed({1'b0, env_q[15:0]});
			envp_s2 <= 64'(env_q) * 64'(cfg.decay);
		end
		if (cmd.post2) begin
			t_s3       <= T_W'(ab_sum >>> 14);
			env_sat_s3 <= |envp_s2[63:62];
			env_new_s3 <= (|envp_s2[63:62]) ? 32'hFFFF_FFFF : envp_s2[61:30];
		end
		if (cmd.post3) begin
			smp_s4 <= SMP_W'(tp >>> 22);
		end
	end

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [0:0]  m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			harm_q      <= '0;
			env_q       <= ENV_ONE;
			sum_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			if (cmd.start) begin
				phase_acc_q <= base;
				harm_q      <= base;
				env_q       <= cmd.restart ? ENV_ONE : env_q;
				sum_q       <= '0;
			end else begin
				if (cmd.issue) begin
					harm_q <= harm_q + ((cfg.wave == WAVE_SAW) ? phase_acc_q
						: {phase_acc_q[PHASE_BITS-2:0], 1'b0});
				end
				if (v_s4) begin
					sum_q <= sum_q + SUM_W'(term_s4);
				end
			end
			if (cmd.finish) begin
				m_tvalid_q  <= 1'b1;
				env_q       <= env_new_s3;
				phase_acc_q <= phase_acc_q + cfg.phase_step;
				priority if (smp_s4 > SMP_MAX) begin
					m_tdata_q <= 32'h7FFF_FFFF;
					m_tuser_q <= 1'b1;
				end else if (smp_s4 < SMP_MIN) begin
					m_tdata_q <= 32'h8000_0000;
					m_tuser_q <= 1'b1;
				end else begin
					m_tdata_q <= smp_s4[31:0];
					m_tuser_q <= env_sat_s3;
				end
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign stat.busy     = c_busy | v_s1 | v_s2 | v_s3 | v_s4;
	assign stat.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ design/fws_ctrl.sv @@
module fws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               restart,
	input  fws_pkg::wave_t     wave,
	input  logic [6:0]         term_limit,
	input  fws_pkg::fws_stat_t stat,
	output fws_pkg::fws_cmd_t  cmd
);
	import fws_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_RUN    = 7'b0000010,
		ST_DRAIN  = 7'b0000100,
		ST_POST1  = 7'b0001000,
		ST_POST2  = 7'b0010000,
		ST_POST3  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	logic [J_W-1:0] j_q, j_d;
	logic [J_W-1:0] nterm;

	always_comb begin
		priority if (wave == WAVE_SINE) begin
			nterm = J_W'(1);
		end else if (32'(term_limit) >= MAX_TERMS) begin
			nterm = J_W'(MAX_TERMS - 1);
		end else if (term_limit == 7'd0) begin
			nterm = '0;
		end else begin
			nterm = J_W'(term_limit - 7'd1);
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.j    = j_q;
		s_tready = 1'b0;
		state_d  = state_q;
		j_d      = j_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start   = 1'b1;
					cmd.restart = restart;
					j_d         = J_W'(1);
					state_d     = (nterm == '0) ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (j_q == nterm) begin
					state_d = ST_DRAIN;
				end else begin
					j_d = j_q + J_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_POST1;
				end
			end
			ST_POST1: begin
				cmd.post1 = 1'b1;
				state_d   = ST_POST2;
			end
			ST_POST2: begin
				cmd.post2 = 1'b1;
				state_d   = ST_POST3;
			end
			ST_POST3: begin
				cmd.post3 = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
		end
	end

endmodule

@@ design/fourier_waveform_synth.sv @@
// Additive Fourier-series waveform generator producing one signed Q16.16 sample per beat.
// Each beat accepted on the s_ stream requests one sample; s_tdata bit 0 is the restart
// flag, which returns the phase to zero and the envelope to one before that sample.
// The sample leaves on the m_ stream with its saturation flag in m_tuser.
// The APB port sets waveform, number of harmonics, phase step, amplitude and the
// per-sample envelope decay; it is to be written only while no sample is in progress,
// which the block itself does not enforce. The number of harmonics summed is
// term_limit - 1, at most 63, and one for the pure sine; with none to sum, the
// controller skips the run state and goes straight to the pipeline drain.
// The harmonics pass through a single 25-stage CORDIC pipeline, one per cycle, followed
// by a four-stage reciprocal divider; the controller then waits for the pipeline to
// drain and runs three scaling steps. One sample is worked on at a time, and the
// next request can be taken in the same cycle that m_tvalid rises. The finished sample
// sits in an output register, so a new request is taken while it waits; a stalled
// receiver holds only the following sample in its final step.
// Reset clears the phase, sets the envelope to one and loads the register defaults.
module fourier_waveform_synth (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sample
	output logic [0:0]  m_tuser    // [0] saturated
);
	import fws_pkg::*;

	fws_cfg_t  cfg_q;
	fws_cmd_t  cmd;
	fws_stat_t stat;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave       <= WAVE_SQUARE;
			cfg_q.term_limit <= 7'd20;
			cfg_q.phase_step <= PHASE_BITS'(2670);
			cfg_q.amplitude  <= 16'sd5120;
			cfg_q.decay      <= 32'h4000_0000;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_WAVE:  cfg_q.wave       <= wave_t'(pwdata[1:0]);
				REG_TERMS: cfg_q.term_limit <= pwdata[6:0];
				REG_STEP:  cfg_q.phase_step <= pwdata[PHASE_BITS-1:0];
				REG_AMP:   cfg_q.amplitude  <= $signed(pwdata[15:0]);
				REG_DECAY: cfg_q.decay      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WAVE:  prdata = 32'(cfg_q.wave);
			REG_TERMS: prdata = 32'(cfg_q.term_limit);
			REG_STEP:  prdata = 32'(cfg_q.phase_step);
			REG_AMP:   prdata = 32'($unsigned(cfg_q.amplitude));
			REG_DECAY: prdata = cfg_q.decay;
			default:   prdata = '0;
		endcase
	end

	fws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.restart    (s_tdata[0]),
		.wave       (cfg_q.wave),
		.term_limit (cfg_q.term_limit),
		.stat       (stat),
		.cmd        (cmd)
	);

	fws_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ verif/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fws_pkg::*;

	typedef struct packed {
		logic [31:0] sample;
		logic        sat;
	} synth_out_t;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     LONG_HOLD   = 400;
	localparam longint S32_MAX     = 64'sd2147483647;
	localparam longint S32_MIN     = -64'sd2147483648;
	localparam longint ROT_GAIN    = 652032874;
	localparam longint TURN_ATAN [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] sample
	logic [0:0]  m_tuser;         // [0] saturated

	fourier_waveform_synth u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	wave_t                  cfg_wave  = WAVE_SQUARE;
	logic [6:0]             cfg_terms = 7'd20;
	logic [PHASE_BITS-1:0]  cfg_step  = PHASE_BITS'(2670);
	logic signed [15:0]     cfg_amp   = 16'sd5120;
	logic [31:0]            cfg_decay = 32'h4000_0000;
	logic [PHASE_BITS-1:0]  phase_acc = '0;
	logic [31:0]            env_level = ENV_ONE;

	logic       restart_backlog [$];
	synth_out_t sample_expect_q [$];

	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  calm = 1'b0;
	int  samples_seen = 0;
	int  mismatches = 0;
	int  cycle_cnt = 0;

	function automatic longint sine_q30(input logic [PHASE_BITS-1:0] ph);
		logic [31:0] ang;
		logic        neg;
		longint      x, y, z, dx, dy;
		ang = 32'(ph) << (32 - PHASE_BITS);
		ang = ang & ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);
		neg = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (neg)
			ang = ang + 32'h8000_0000;
		x = ROT_GAIN;
		y = 0;
		z = longint'($signed(ang));
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - TURN_ATAN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + TURN_ATAN[i];
			end
		end
		return neg ? -y : y;
	endfunction

	function automatic longint harmonic_sum(input logic [PHASE_BITS-1:0] ph);
		longint      acc, s, d;
		int          n, k;
		logic [31:0] prod;
		if (cfg_wave == WAVE_SINE)
			return sine_q30(ph);
		n = (cfg_terms > MAX_TERMS) ? MAX_TERMS : int'(cfg_terms);
		acc = 0;
		for (int j = 1; j < n; j++) begin
			k = (cfg_wave == WAVE_SAW) ? j : 2 * j - 1;
			prod = 32'(k) * 32'(ph);
			s = sine_q30(prod[PHASE_BITS-1:0]);
			if (cfg_wave != WAVE_SQUARE && (j % 2) == 1)
				s = -s;
			d = longint'(k);
			if (cfg_wave == WAVE_TRIANGLE)
				d = d * d;
			acc = acc + s / d;
		end
		return acc;
	endfunction

	function automatic synth_out_t next_sample(input logic restart);
		longint      ser, pa, pb, t, smp;
		logic [63:0] env_prod;
		synth_out_t  r;
		r.sat = 1'b0;
		if (restart) begin
			phase_acc = '0;
			env_level = ENV_ONE;
		end
		ser = harmonic_sum(phase_acc);
		pa = ser * longint'(env_level[31:16]);
		pb = ser * longint'(env_level[15:0]);
		t = (pa + (pb >>> 16)) >>> 14;
		smp = (t * longint'(cfg_amp)) >>> 22;
		if (smp > S32_MAX) begin
			smp = S32_MAX;
			r.sat = 1'b1;
		end
		if (smp < S32_MIN) begin
			smp = S32_MIN;
			r.sat = 1'b1;
		end
		env_prod = ({32'd0, env_level} * {32'd0, cfg_decay}) >> 30;
		if (env_prod > 64'hFFFF_FFFF) begin
			env_prod = 64'hFFFF_FFFF;
			r.sat = 1'b1;
		end
		env_level = env_prod[31:0];
		phase_acc = phase_acc + cfg_step;
		r.sample = smp[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				sample_expect_q.push_back(next_sample(s_tdata[0]));
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (restart_backlog.size() > 0 && !calm &&
						$urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 16);
					s_tvalid <= 1'b0;
				end else if (restart_backlog.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, restart_backlog.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		synth_out_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				samples_seen <= samples_seen + 1;
				if (sample_expect_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected beat: sample %h saturated %b",
							m_tdata, m_tuser[0]);
				end else begin
					e = sample_expect_q.pop_front();
					if (m_tdata !== e.sample || m_tuser[0] !== e.sat) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("beat %0d: expected %h/%b, got %h/%b",
								samples_seen, e.sample, e.sat, m_tdata, m_tuser[0]);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && restart_backlog.size() > 20 &&
					samples_seen > 100) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WAVE:  cfg_wave = wave_t'(value[1:0]);
			REG_TERMS: cfg_terms = value[6:0];
			REG_STEP:  cfg_step = value[PHASE_BITS-1:0];
			REG_AMP:   cfg_amp = value[15:0];
			REG_DECAY: cfg_decay = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (restart_backlog.size() != 0 || s_tvalid || sample_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic play(input int count, input int restart_pct);
		for (int i = 0; i < count; i++)
			restart_backlog.push_back($urandom_range(0, 99) < restart_pct);
		wait_drained();
	endtask

	task automatic set_all(input wave_t w, input logic [6:0] terms,
			input logic [31:0] step, input logic [15:0] amp, input logic [31:0] decay);
		write_reg(REG_WAVE, 32'(w));
		write_reg(REG_TERMS, 32'(terms));
		write_reg(REG_STEP, step);
		write_reg(REG_AMP, 32'(amp));
		write_reg(REG_DECAY, decay);
	endtask

	initial begin
		int          sent;
		int          pick;
		logic [6:0]  terms;
		logic [31:0] step;
		logic [31:0] decay;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		play(1, 100);
		play(2, 0);
		write_reg(REG_TERMS, 32'd0);
		play(1, 0);
		write_reg(REG_TERMS, 32'd1);
		play(1, 0);
		write_reg(REG_TERMS, 32'd127);
		play(2, 0);
		set_all(WAVE_TRIANGLE, 7'd64, 32'h00FF_FFFF, 16'h7FFF, 32'h4000_0000);
		play(2, 0);
		set_all(WAVE_SAW, 7'd33, 32'd123457, 16'h8000, 32'h3F00_0000);
		play(3, 0);
		set_all(WAVE_SINE, 7'd0, 32'd40000, 16'h8000, 32'hFFFF_FFFF);
		play(1, 100);
		play(2, 0);
		set_all(WAVE_SQUARE, 7'd2, 32'd0, 16'h0100, 32'd0);
		play(1, 100);
		play(2, 0);
		write_reg(REG_AMP, 32'd0);
		play(2, 50);
		sent = 20;

		while (sent < 520) begin
			pick = $urandom_range(0, 9);
			terms = (pick < 7) ? 7'($urandom_range(0, 24)) :
				(pick < 9) ? 7'($urandom_range(25, 63)) : 7'($urandom_range(64, 127));
			step = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4000);
			case ($urandom_range(0, 5))
				0: decay = 32'h4000_0000 - $urandom_range(0, 1 << 20);
				1: decay = 32'h4000_0000 + $urandom_range(0, 1 << 16);
				2: decay = $urandom;
				3: decay = 32'd0;
				4: decay = 32'hFFFF_FFFF;
				default: decay = 32'h4000_0000;
			endcase
			set_all(wave_t'($urandom_range(0, 3)), terms, step, 16'($urandom), decay);
			pick = $urandom_range(30, 60);
			play(pick, 8);
			sent = sent + pick;
		end

		calm = 1'b1;
		set_all(WAVE_TRIANGLE, 7'd15, 32'd9001, 16'h1400, 32'h3FFF_0000);
		play(30, 8);

		repeat (120) @(posedge clk);
		if (mismatches == 0 && sample_expect_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/fws_pkg.sv
design/fws_cordic.sv
design/fws_datapath.sv
design/fws_ctrl.sv
design/fourier_waveform_synth.sv
verif/tb.sv
